// ----- rtl/shake_gesture_detector_macros.svh -----
// Assertion macros used by the RTL that carries checks.
`ifndef SHAKE_GESTURE_DETECTOR_MACROS_SVH
`define SHAKE_GESTURE_DETECTOR_MACROS_SVH

`ifndef ASSERT_OFF
// A property that must hold at every clock edge outside reset.
`define SGD_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// A condition that must be followed by another one in the next cycle.
`define SGD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SGD_ASSERT(lbl, clk, rst_n, prop, msg)
`define SGD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ----- rtl/sgd_pkg.sv -----
`default_nettype none

package sgd_pkg;

	// Field widths.
	localparam int STAMP_W   = 32;
	localparam int AXIS_W    = 16;
	localparam int MIN_W     = 5;
	localparam int HELD_W    = 5;
	localparam int MS_W      = 16;
	localparam int CFG_W     = 32;
	localparam int CFG_IDX_W = 3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_POLL_INTERVAL = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_JOLT_WINDOW   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_JOLT_MIN      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_SQ       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_SQ        = 3'd5;

	// Register values after reset.
	localparam logic [MS_W-1:0]    RST_POLL_INTERVAL = 16'd20;
	localparam logic [MS_W-1:0]    RST_JOLT_WINDOW   = 16'd700;
	localparam logic [MIN_W-1:0]   RST_JOLT_MIN      = 5'd4;
	localparam logic [MS_W-1:0]    RST_COOLDOWN      = 16'd1200;
	localparam logic [STAMP_W-1:0] RST_HIGH_SQ       = 32'd60565749;
	localparam logic [STAMP_W-1:0] RST_LOW_SQ        = 32'd167773;

	// Sequencer states, one-hot.
	typedef enum logic [5:0] {
		ST_IDLE    = 6'b000001,
		ST_GATE    = 6'b000010,
		ST_COMPACT = 6'b000100,
		ST_APPEND  = 6'b001000,
		ST_FIRE    = 6'b010000,
		ST_DONE    = 6'b100000
	} st_t;

	// Per-cell control: take the right neighbor's stamp, or load the new stamp.
	typedef struct packed {
		logic shift;
		logic load;
	} cell_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/sgd_cell.sv -----
`default_nettype none

module sgd_cell (
	input  wire logic                        clk,
	input  wire sgd_pkg::cell_ctl_t          ctl,
	input  wire logic [sgd_pkg::STAMP_W-1:0] load_data,
	input  wire logic [sgd_pkg::STAMP_W-1:0] right_data,
	output logic      [sgd_pkg::STAMP_W-1:0] stamp
);
	import sgd_pkg::*;

	logic [STAMP_W-1:0] stamp_q;

	// A new stamp wins over a shift; otherwise the cell holds.
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			stamp_q <= load_data;
		end else if (ctl.shift) begin
			stamp_q <= right_data;
		end
	end

	assign stamp = stamp_q;

endmodule

`default_nettype wire

// ----- rtl/sgd_mag.sv -----
`default_nettype none

module sgd_mag (
	input  wire logic                               clk,
	input  wire logic                               en,
	input  wire logic signed [sgd_pkg::AXIS_W-1:0]  acc_x,
	input  wire logic signed [sgd_pkg::AXIS_W-1:0]  acc_y,
	input  wire logic signed [sgd_pkg::AXIS_W-1:0]  acc_z,
	output logic             [sgd_pkg::STAMP_W-1:0] sq_sum
);
	import sgd_pkg::*;

	logic signed [2*AXIS_W-1:0] sq_x, sq_y, sq_z;
	logic        [2*AXIS_W-1:0] sq_x_s1, sq_y_s1, sq_z_s1;

	// Each square is at most 2^30, so the signed product is never negative.
	assign sq_x = acc_x * acc_x;
	assign sq_y = acc_y * acc_y;
	assign sq_z = acc_z * acc_z;

	always_ff @(posedge clk) begin
		if (en) begin
			sq_x_s1 <= $unsigned(sq_x);
			sq_y_s1 <= $unsigned(sq_y);
			sq_z_s1 <= $unsigned(sq_z);
		end
	end

	// The sum is at most 3 * 2^30 and fits in 32 bits.
	assign sq_sum = STAMP_W'(sq_x_s1 + sq_y_s1 + sq_z_s1);

endmodule

`default_nettype wire

// ----- rtl/shake_gesture_detector.sv -----
// Shake gesture detector. Each request carries a millisecond time, a read
// status, three raw accelerometer axes and a finger-down flag, and yields
// exactly one result. A request inside the poll interval only reports the
// counters. The squared magnitude is tested against two bounds; on a jolt,
// the stamps held in a chain of JOLT_SLOTS cells are compacted by shifting
// the expired ones out, one stored stamp per cycle, and the new stamp is
// appended. The compaction pass walks the stamps held before the jolt,
// at most JOLT_SLOTS; a gated request, a failed read or a request
// without a jolt skips it. A finished result waits in the output
// register while the next request is taken. Configuration writes are
// taken at any time and act at once.
`default_nettype none

`include "shake_gesture_detector_macros.svh"

module shake_gesture_detector #(
	parameter int JOLT_SLOTS = 16
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// Configuration port.
	input  wire logic                                cfg_we,
	input  wire logic [sgd_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [sgd_pkg::CFG_W-1:0]           cfg_data,
	// Request channel.
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic [sgd_pkg::STAMP_W-1:0]         now_ms,
	input  wire logic                                sample_ok,
	input  wire logic signed [sgd_pkg::AXIS_W-1:0]   acc_x,
	input  wire logic signed [sgd_pkg::AXIS_W-1:0]   acc_y,
	input  wire logic signed [sgd_pkg::AXIS_W-1:0]   acc_z,
	input  wire logic                                finger_down,
	// Result channel.
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic                                     polled,
	output logic                                     jolt_seen,
	output logic                                     shake_fired,
	output logic [sgd_pkg::STAMP_W-1:0]              shake_count,
	output logic [sgd_pkg::STAMP_W-1:0]              read_failures,
	output logic [sgd_pkg::HELD_W-1:0]               held_jolts
);
	import sgd_pkg::*;

	localparam int CNT_W = $clog2(JOLT_SLOTS + 1);
	localparam int IDX_W = (JOLT_SLOTS > 1) ? $clog2(JOLT_SLOTS) : 1;
	localparam int CMP_W = (CNT_W > MIN_W) ? CNT_W : MIN_W;
	localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(JOLT_SLOTS);

	// Configuration registers.
	logic [MS_W-1:0]    poll_interval_q;
	logic [MS_W-1:0]    jolt_window_q;
	logic [MIN_W-1:0]   jolt_min_q;
	logic [MS_W-1:0]    cooldown_q;
	logic [STAMP_W-1:0] high_sq_q;
	logic [STAMP_W-1:0] low_sq_q;

	// Detector state.
	st_t                state_q;
	logic [STAMP_W-1:0] last_poll_q;
	logic [STAMP_W-1:0] cooldown_end_q;
	logic [STAMP_W-1:0] shake_cnt_q;
	logic [STAMP_W-1:0] fail_cnt_q;
	logic [CNT_W-1:0]   total_q;
	logic [CNT_W-1:0]   ptr_q;

	// Latched request and per-request flags.
	logic [STAMP_W-1:0] now_q;
	logic               ok_q;
	logic               finger_q;
	logic               polled_q;
	logic               jolt_q;
	logic               fired_q;

	// Result register.
	logic               out_valid_q;
	logic               res_polled_q;
	logic               res_jolt_q;
	logic               res_fired_q;
	logic [STAMP_W-1:0] res_shake_q;
	logic [STAMP_W-1:0] res_fail_q;
	logic [HELD_W-1:0]  res_held_q;

	logic               in_accept;
	logic               out_free;
	logic [STAMP_W-1:0] sq_sum;
	logic               gated;
	logic               is_jolt;
	logic [STAMP_W-1:0] head_stamp;
	logic               keep;
	logic               ptr_done;
	logic               fire_go;
	cell_ctl_t          cell_ctl  [JOLT_SLOTS];
	logic [STAMP_W-1:0] cell_stamp[JOLT_SLOTS];

	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;

	// Configuration writes; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poll_interval_q <= RST_POLL_INTERVAL;
			jolt_window_q   <= RST_JOLT_WINDOW;
			jolt_min_q      <= RST_JOLT_MIN;
			cooldown_q      <= RST_COOLDOWN;
			high_sq_q       <= RST_HIGH_SQ;
			low_sq_q        <= RST_LOW_SQ;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_POLL_INTERVAL: poll_interval_q <= cfg_data[MS_W-1:0];
				REG_JOLT_WINDOW:   jolt_window_q   <= cfg_data[MS_W-1:0];
				REG_JOLT_MIN:      jolt_min_q      <= cfg_data[MIN_W-1:0];
				REG_COOLDOWN:      cooldown_q      <= cfg_data[MS_W-1:0];
				REG_HIGH_SQ:       high_sq_q       <= cfg_data;
				REG_LOW_SQ:        low_sq_q        <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Squared magnitude, captured as the request is taken.
	sgd_mag u_mag (
		.clk    (clk),
		.en     (in_accept),
		.acc_x  (acc_x),
		.acc_y  (acc_y),
		.acc_z  (acc_z),
		.sq_sum (sq_sum)
	);

	// Poll gate and jolt test.
	assign gated   = (now_q - last_poll_q) < STAMP_W'(poll_interval_q);
	assign is_jolt = (sq_sum > high_sq_q) || (sq_sum < low_sq_q);

	// Compaction looks at the stamp under the pointer.
	assign head_stamp = cell_stamp[ptr_q[IDX_W-1:0]];
	assign keep       = (now_q - head_stamp) <= STAMP_W'(jolt_window_q);
	assign ptr_done   = (ptr_q >= total_q);

	// Fire test.
	assign fire_go = (CMP_W'(total_q) >= CMP_W'(jolt_min_q)) &&
		(now_q >= cooldown_end_q) && !finger_q;

	// Cell controls: expired stamps are squeezed out by shifting the tail left.
	always_comb begin
		for (int j = 0; j < JOLT_SLOTS; j++) begin
			cell_ctl[j].shift = (state_q == ST_COMPACT) && !ptr_done && !keep &&
				(CNT_W'(j) >= ptr_q);
			cell_ctl[j].load  = (state_q == ST_APPEND) && (total_q < SLOTS_C) &&
				(total_q == CNT_W'(j));
		end
	end

	// Chain of stamp cells.
	for (genvar g = 0; g < JOLT_SLOTS; g++) begin : g_cell
		logic [STAMP_W-1:0] right;
		if (g < JOLT_SLOTS - 1) begin : g_mid
			assign right = cell_stamp[g+1];
		end else begin : g_end
			assign right = cell_stamp[g];
		end
		sgd_cell u_cell (
			.clk        (clk),
			.ctl        (cell_ctl[g]),
			.load_data  (now_q),
			.right_data (right),
			.stamp      (cell_stamp[g])
		);
	end

	// Latch the request payload.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			now_q    <= now_ms;
			ok_q     <= sample_ok;
			finger_q <= finger_down;
		end
	end

	// Sequencer and detector state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			last_poll_q    <= '0;
			cooldown_end_q <= '0;
			shake_cnt_q    <= '0;
			fail_cnt_q     <= '0;
			total_q        <= '0;
			ptr_q          <= '0;
			polled_q       <= 1'b0;
			jolt_q         <= 1'b0;
			fired_q        <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						state_q <= ST_GATE;
					end
				end
				ST_GATE: begin
					jolt_q  <= 1'b0;
					fired_q <= 1'b0;
					if (gated) begin
						polled_q <= 1'b0;
						state_q  <= ST_DONE;
					end else begin
						polled_q    <= 1'b1;
						last_poll_q <= now_q;
						if (!ok_q) begin
							fail_cnt_q <= fail_cnt_q + 1'b1;
							state_q    <= ST_DONE;
						end else if (is_jolt) begin
							jolt_q  <= 1'b1;
							ptr_q   <= '0;
							state_q <= ST_COMPACT;
						end else begin
							state_q <= ST_FIRE;
						end
					end
				end
				ST_COMPACT: begin
					if (ptr_done) begin
						state_q <= ST_APPEND;
					end else if (keep) begin
						ptr_q <= ptr_q + 1'b1;
					end else begin
						total_q <= total_q - 1'b1;
					end
				end
				ST_APPEND: begin
					if (total_q < SLOTS_C) begin
						total_q <= total_q + 1'b1;
					end
					state_q <= ST_FIRE;
				end
				ST_FIRE: begin
					if (fire_go) begin
						cooldown_end_q <= now_q + STAMP_W'(cooldown_q);
						total_q        <= '0;
						shake_cnt_q    <= shake_cnt_q + 1'b1;
						fired_q        <= 1'b1;
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_DONE) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if ((state_q == ST_DONE) && out_free) begin
			res_polled_q <= polled_q;
			res_jolt_q   <= jolt_q;
			res_fired_q  <= fired_q;
			res_shake_q  <= shake_cnt_q;
			res_fail_q   <= fail_cnt_q;
			res_held_q   <= HELD_W'(total_q);
		end
	end

	assign out_valid     = out_valid_q;
	assign polled        = res_polled_q;
	assign jolt_seen     = res_jolt_q;
	assign shake_fired   = res_fired_q;
	assign shake_count   = res_shake_q;
	assign read_failures = res_fail_q;
	assign held_jolts    = res_held_q;

	// Checks.
	`SGD_ASSERT(a_total_bound, clk, arst_n, total_q <= SLOTS_C,
		"held stamp count exceeds the cell chain")
	`SGD_ASSERT(a_ptr_bound, clk, arst_n, (state_q != ST_COMPACT) || (ptr_q <= total_q),
		"compaction pointer ran past the held stamps")
	`SGD_ASSERT_NEXT(a_accept_gate, clk, arst_n, in_accept, state_q == ST_GATE,
		"accepted request did not reach the poll gate")
	`SGD_ASSERT_NEXT(a_fire_clear, clk, arst_n, (state_q == ST_FIRE) && fire_go,
		(total_q == '0) && (shake_cnt_q == $past(shake_cnt_q) + 1'b1),
		"shake did not clear the stamps and count")

endmodule

`default_nettype wire
